FILE: hdl/rrts_pkg.sv
// Package for the round-robin thread slot scheduler: slot state codes, opcodes,
// status codes, the request and response word types and the control/status structs.
// Depends on nothing.
package rrts_pkg;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = 4;
   localparam int STATE_W = 3;
   localparam int STAT_W  = 3;

   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_YIELD  = 2'd1;
   localparam logic [OP_W-1:0] OP_JOIN   = 2'd2;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

   localparam logic [STATE_W-1:0] ST_FREE     = 3'd0;
   localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd1;
   localparam logic [STATE_W-1:0] ST_RUNNABLE = 3'd2;
   localparam logic [STATE_W-1:0] ST_DONE     = 3'd3;
   localparam logic [STATE_W-1:0] ST_JOINED   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOFREE  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_INVALID = 3'd2;
   localparam logic [STAT_W-1:0] STAT_JOINED  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BLOCKED = 3'd4;

   localparam logic [1:0] SEL_CUR = 2'd0;
   localparam logic [1:0] SEL_TGT = 2'd1;
   localparam logic [1:0] SEL_HIT = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [SLOT_W-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] created_slot;
      logic [SLOT_W-1:0] active_slot;
      logic              switched;
   } rsp_type;

   typedef struct packed {
      logic               load_req;
      logic               rd_en;
      logic [1:0]         rd_sel;
      logic               wr_en;
      logic [1:0]         wr_sel;
      logic [STATE_W-1:0] wr_state;
      logic               old_from_rd;
      logic               old_set_done;
      logic               scan_start;
      logic               scan_create;
      logic               scan_run;
      logic               set_status;
      logic [STAT_W-1:0]  status;
      logic               set_created;
      logic               set_cur;
      logic               out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic               tgt_bad;
      logic [STATE_W-1:0] rd_state;
      logic               scan_hit;
      logic               scan_end;
      logic               old_running;
   } sts_type;

endpackage

FILE: hdl/rrts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rrts_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rrts_datapath.sv
// Scheduler datapath: slot state RAM with reset-valid bits, current slot, scan
// counter and the response register. Depends on rrts_pkg and rrts_ram.
module rrts_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  rrts_pkg::req_type req_data,
   input  rrts_pkg::cmd_type cmd,
   output rrts_pkg::sts_type sts,
   output rrts_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int XW = (AW > rrts_pkg::SLOT_W) ? AW : rrts_pkg::SLOT_W;

   rrts_pkg::req_type                  req_ff;
   rrts_pkg::rsp_type                  rsp_ff;
   logic [AW-1:0]                      cur_ff, cur_in;
   logic [AW-1:0]                      before_ff;
   logic [AW-1:0]                      created_ff;
   logic [rrts_pkg::STAT_W-1:0]        status_ff;
   logic [NUM_SLOTS-1:0]               valid_ff;
   logic [AW-1:0]                      raddr_ff;
   logic [AW-1:0]                      idx_ff, idx_in;
   logic [AW:0]                        cnt_ff, cnt_in;
   logic [AW:0]                        total_ff;
   logic                               create_ff;
   logic                               pend_ff;
   logic [AW-1:0]                      hit_ff;
   logic [rrts_pkg::STATE_W-1:0]       old_st_ff;

   logic [XW-1:0]                      tgt_wide;
   logic [AW-1:0]                      tgt_addr;
   logic                               scan_issue;
   logic                               rd_any;
   logic [AW-1:0]                      rd_addr;
   logic [AW-1:0]                      wr_addr;
   logic [rrts_pkg::STATE_W-1:0]       ram_rdata;
   logic [rrts_pkg::STATE_W-1:0]       rd_state;
   logic                               match;
   logic [AW-1:0]                      cur_next;
   logic [XW-1:0]                      created_wide;
   logic [XW-1:0]                      cur_wide;

   assign tgt_wide   = XW'(req_ff.target_slot);
   assign tgt_addr   = tgt_wide[AW-1:0];
   assign scan_issue = cmd.scan_run && (cnt_ff != total_ff);
   assign rd_any     = cmd.rd_en || scan_issue;
   assign cur_next   = (cur_ff == AW'(NUM_SLOTS - 1)) ? '0 : cur_ff + 1'b1;

   always_comb begin
      rd_addr = cur_ff;
      if (scan_issue) begin
         rd_addr = idx_ff;
      end else if (cmd.rd_sel == rrts_pkg::SEL_TGT) begin
         rd_addr = tgt_addr;
      end
   end

   always_comb begin
      unique case (cmd.wr_sel)
         rrts_pkg::SEL_TGT: wr_addr = tgt_addr;
         rrts_pkg::SEL_HIT: wr_addr = hit_ff;
         default:           wr_addr = cur_ff;
      endcase
   end

   rrts_ram #(
      .WIDTH (rrts_pkg::STATE_W),
      .DEPTH (NUM_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.wr_state),
      .rd_en   (rd_any),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (valid_ff[raddr_ff]) begin
         rd_state = ram_rdata;
      end else if (raddr_ff == '0) begin
         rd_state = rrts_pkg::ST_RUNNING;
      end else begin
         rd_state = rrts_pkg::ST_FREE;
      end
   end

   assign match = create_ff ? (rd_state == rrts_pkg::ST_FREE || rd_state == rrts_pkg::ST_JOINED)
                            : (rd_state == rrts_pkg::ST_RUNNABLE);

   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (cmd.scan_start) begin
         idx_in = cmd.scan_create ? AW'(1) : cur_next;
         cnt_in = '0;
      end else if (scan_issue) begin
         idx_in = (idx_ff == AW'(NUM_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.set_cur) begin
         cur_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         cur_ff  <= cur_in;
         pend_ff <= scan_issue;
         if (cmd.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (rd_any) begin
         raddr_ff <= rd_addr;
      end
      if (cmd.load_req) begin
         req_ff     <= req_data;
         before_ff  <= cur_ff;
         status_ff  <= rrts_pkg::STAT_OK;
         created_ff <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.set_created) begin
            created_ff <= hit_ff;
         end
      end
      if (cmd.scan_start) begin
         create_ff <= cmd.scan_create;
         total_ff  <= cmd.scan_create ? (AW+1)'(NUM_SLOTS - 1) : (AW+1)'(NUM_SLOTS);
      end
      if (cmd.scan_run && pend_ff && match) begin
         hit_ff <= raddr_ff;
      end
      if (cmd.old_set_done) begin
         old_st_ff <= rrts_pkg::ST_DONE;
      end else if (cmd.old_from_rd) begin
         old_st_ff <= rd_state;
      end
      if (cmd.out_load) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.created_slot <= created_wide[rrts_pkg::SLOT_W-1:0];
         rsp_ff.active_slot  <= cur_wide[rrts_pkg::SLOT_W-1:0];
         rsp_ff.switched     <= (cur_ff != before_ff);
      end
   end

   assign created_wide = XW'(created_ff);
   assign cur_wide     = XW'(cur_ff);

   assign sts.opcode      = req_ff.opcode;
   assign sts.tgt_bad     = (req_ff.target_slot == '0) ||
                            (32'(req_ff.target_slot) >= 32'(NUM_SLOTS));
   assign sts.rd_state    = rd_state;
   assign sts.scan_hit    = pend_ff && match;
   assign sts.scan_end    = !pend_ff && (cnt_ff == total_ff);
   assign sts.old_running = (old_st_ff == rrts_pkg::ST_RUNNING);

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/rrts_ctrl.sv
// Scheduler controller: state machine that sequences reads, the slot scan and
// writes of the datapath, and owns the handshakes. Depends on rrts_pkg.
module rrts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrts_pkg::cmd_type cmd,
   input  rrts_pkg::sts_type sts
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_RD_OLD  = 4'd2;
   localparam logic [3:0] S_OLD_CHK = 4'd3;
   localparam logic [3:0] S_TGT_CHK = 4'd4;
   localparam logic [3:0] S_SCAN    = 4'd5;
   localparam logic [3:0] S_CRT_WR  = 4'd6;
   localparam logic [3:0] S_Y_OLD   = 4'd7;
   localparam logic [3:0] S_Y_NEW   = 4'd8;
   localparam logic [3:0] S_RESP    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.opcode)
               rrts_pkg::OP_CREATE: begin
                  cmd.scan_start  = 1'b1;
                  cmd.scan_create = 1'b1;
                  state_in        = S_SCAN;
               end
               rrts_pkg::OP_YIELD: begin
                  state_in = S_RD_OLD;
               end
               rrts_pkg::OP_JOIN: begin
                  if (sts.tgt_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = rrts_pkg::STAT_INVALID;
                     state_in       = S_RESP;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = rrts_pkg::SEL_TGT;
                     state_in   = S_TGT_CHK;
                  end
               end
               default: begin
                  cmd.wr_en        = 1'b1;
                  cmd.wr_sel       = rrts_pkg::SEL_CUR;
                  cmd.wr_state     = rrts_pkg::ST_DONE;
                  cmd.old_set_done = 1'b1;
                  cmd.scan_start   = 1'b1;
                  state_in         = S_SCAN;
               end
            endcase
         end
         S_RD_OLD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = rrts_pkg::SEL_CUR;
            state_in   = S_OLD_CHK;
         end
         S_OLD_CHK: begin
            cmd.old_from_rd = 1'b1;
            cmd.scan_start  = 1'b1;
            state_in        = S_SCAN;
         end
         S_TGT_CHK: begin
            case (sts.rd_state)
               rrts_pkg::ST_FREE: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rrts_pkg::STAT_INVALID;
                  state_in       = S_RESP;
               end
               rrts_pkg::ST_JOINED: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rrts_pkg::STAT_JOINED;
                  state_in       = S_RESP;
               end
               rrts_pkg::ST_DONE: begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_sel   = rrts_pkg::SEL_TGT;
                  cmd.wr_state = rrts_pkg::ST_JOINED;
                  state_in     = S_RESP;
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rrts_pkg::STAT_BLOCKED;
                  cmd.rd_en      = 1'b1;
                  cmd.rd_sel     = rrts_pkg::SEL_CUR;
                  state_in       = S_OLD_CHK;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_hit) begin
               state_in = (sts.opcode == rrts_pkg::OP_CREATE) ? S_CRT_WR : S_Y_OLD;
            end else if (sts.scan_end) begin
               if (sts.opcode == rrts_pkg::OP_CREATE) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = rrts_pkg::STAT_NOFREE;
               end
               state_in = S_RESP;
            end
         end
         S_CRT_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = rrts_pkg::SEL_HIT;
            cmd.wr_state    = rrts_pkg::ST_RUNNABLE;
            cmd.set_created = 1'b1;
            state_in        = S_RESP;
         end
         S_Y_OLD: begin
            cmd.wr_en    = sts.old_running;
            cmd.wr_sel   = rrts_pkg::SEL_CUR;
            cmd.wr_state = rrts_pkg::ST_RUNNABLE;
            state_in     = S_Y_NEW;
         end
         S_Y_NEW: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = rrts_pkg::SEL_HIT;
            cmd.wr_state = rrts_pkg::ST_RUNNING;
            cmd.set_cur  = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/round_robin_thread_slot_scheduler.sv
// Top level of the round-robin thread slot scheduler: joins controller and datapath.
// Depends on rrts_pkg, rrts_ctrl, rrts_datapath and rrts_ram.
//
//   channel   ports                            word
//   request   req_valid req_ready req_data     rrts_pkg::req_type
//   response  rsp_valid rsp_ready rsp_data     rrts_pkg::rsp_type
//
// One request is handled at a time; the slot scan reads the state RAM once per cycle.
// After reset slot 0 is running and the others free; no clearing pass is needed.
// A stalled response holds; the next request is taken while it waits.
module round_robin_thread_slot_scheduler #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrts_pkg::rsp_type rsp_data
);

   rrts_pkg::cmd_type cmd;
   rrts_pkg::sts_type sts;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rrts_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request was in progress");

   a_created_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != rrts_pkg::STAT_OK |-> rsp_data.created_slot == '0)
      else $error("created slot reported with a failing status");

   a_switch_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switched |->
         rsp_data.status == rrts_pkg::STAT_OK || rsp_data.status == rrts_pkg::STAT_BLOCKED)
      else $error("slot switch reported with an error status");

endmodule

FILE: verif/rrts_sched_tb_pkg.sv
// Scoreboard for the round-robin thread slot scheduler testbench: a model of the slot
// states and the current slot that predicts each response word and checks the DUT's.
// Depends on rrts_pkg for the word types, opcodes, slot states and status codes.
`timescale 1ns / 1ps
package rrts_sched_tb_pkg;
   import rrts_pkg::*;

   localparam int NUM_SLOTS = 16;

   class slot_schedule_board;
      logic [STATE_W-1:0] slot_state [NUM_SLOTS];
      logic [SLOT_W-1:0]  cur_slot;
      rsp_type            pending_replies [$];
      int                 failures;
      int                 reported;
      int                 checked;
      int                 op_count [4];
      int                 status_count [5];

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state[i] = ST_FREE;
         end
         slot_state[0] = ST_RUNNING;
         cur_slot = '0;
         failures = 0;
         reported = 0;
         checked = 0;
         for (int i = 0; i < 4; i++) begin
            op_count[i] = 0;
         end
         for (int i = 0; i < 5; i++) begin
            status_count[i] = 0;
         end
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void pass_control();
         int old;
         int idx;
         old = cur_slot;
         for (int i = 1; i <= NUM_SLOTS; i++) begin
            idx = (old + i) % NUM_SLOTS;
            if (slot_state[idx] == ST_RUNNABLE) begin
               if (slot_state[old] == ST_RUNNING) begin
                  slot_state[old] = ST_RUNNABLE;
               end
               slot_state[idx] = ST_RUNNING;
               cur_slot = idx[SLOT_W-1:0];
               return;
            end
         end
      endfunction

      function void note_request(req_type word);
         rsp_type           reply;
         logic [SLOT_W-1:0] prior;
         int                tgt;
         prior = cur_slot;
         tgt = word.target_slot;
         reply = '0;
         reply.status = STAT_OK;
         case (word.opcode)
            OP_CREATE: begin
               reply.status = STAT_NOFREE;
               for (int i = 1; i < NUM_SLOTS; i++) begin
                  if (slot_state[i] == ST_FREE || slot_state[i] == ST_JOINED) begin
                     slot_state[i] = ST_RUNNABLE;
                     reply.created_slot = i[SLOT_W-1:0];
                     reply.status = STAT_OK;
                     break;
                  end
               end
            end
            OP_YIELD: begin
               pass_control();
            end
            OP_JOIN: begin
               if (tgt == 0 || tgt >= NUM_SLOTS || slot_state[tgt] == ST_FREE) begin
                  reply.status = STAT_INVALID;
               end else if (slot_state[tgt] == ST_JOINED) begin
                  reply.status = STAT_JOINED;
               end else if (slot_state[tgt] == ST_DONE) begin
                  slot_state[tgt] = ST_JOINED;
               end else begin
                  pass_control();
                  reply.status = STAT_BLOCKED;
               end
            end
            default: begin
               slot_state[cur_slot] = ST_DONE;
               pass_control();
            end
         endcase
         reply.active_slot = cur_slot;
         reply.switched = (cur_slot != prior);
         op_count[word.opcode]++;
         status_count[reply.status]++;
         pending_replies.push_back(reply);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected response word: status %0d created %0d active %0d",
                        got.status, got.created_slot, got.active_slot);
               $display("   switched %0d", got.switched);
            end
            return;
         end
         want = pending_replies.pop_front();
         checked++;
         if (got.status !== want.status || got.created_slot !== want.created_slot ||
             got.active_slot !== want.active_slot || got.switched !== want.switched) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("response %0d: expected status %0d created %0d active %0d switched %0d",
                        checked, want.status, want.created_slot, want.active_slot,
                        want.switched);
               $display("   got status %0d created %0d active %0d switched %0d",
                        got.status, got.created_slot, got.active_slot, got.switched);
            end
         end
      endfunction

      function void report_leftover();
         if (pending_replies.size() != 0) begin
            failures += pending_replies.size();
            $display("%0d response words never arrived", pending_replies.size());
         end
      endfunction
   endclass

endpackage

FILE: verif/tb_round_robin_thread_slot_scheduler.sv
// Testbench for the round-robin thread slot scheduler: directed and random requests with
// random sender gaps and receiver stalls, every response checked against a scoreboard.
// Depends on rrts_pkg, rrts_sched_tb_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module tb_round_robin_thread_slot_scheduler;
   import rrts_pkg::*;
   import rrts_sched_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1700;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   slot_schedule_board board = new();

   int stall_left = 0;
   int stall_mode = 0;

   round_robin_thread_slot_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(1, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ready <= 1'b0;
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_data);
      end
   end

   function automatic req_type make_req(logic [OP_W-1:0] op, logic [SLOT_W-1:0] tgt);
      req_type word;
      word.opcode = op;
      word.target_slot = tgt;
      return word;
   endfunction

   task automatic send_word(req_type word);
      req_valid <= 1'b1;
      req_data <= word;
      do begin
         @(posedge clock);
      end while (!req_ready);
      board.note_request(word);
   endtask

   task automatic idle(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic req_type pick_request(int mix);
      int                roll;
      int                done_slots [$];
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] tgt;
      roll = $urandom_range(0, 99);
      case (mix)
         0: op = (roll < 30) ? OP_CREATE : (roll < 55) ? OP_YIELD :
                 (roll < 80) ? OP_JOIN : OP_FINISH;
         1: op = (roll < 60) ? OP_CREATE : (roll < 75) ? OP_YIELD :
                 (roll < 90) ? OP_JOIN : OP_FINISH;
         default: op = (roll < 10) ? OP_CREATE : (roll < 25) ? OP_YIELD :
                       (roll < 60) ? OP_JOIN : OP_FINISH;
      endcase
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (board.slot_state[i] == ST_DONE) begin
            done_slots.push_back(i);
         end
      end
      roll = $urandom_range(0, 3);
      if (roll < 2 && done_slots.size() != 0) begin
         tgt = SLOT_W'(done_slots[$urandom_range(0, done_slots.size() - 1)]);
      end else if (roll == 2) begin
         tgt = board.cur_slot;
      end else begin
         tgt = SLOT_W'($urandom_range(0, 15));
      end
      return make_req(op, tgt);
   endfunction

   initial begin
      int sent;
      int burst;
      int mix;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(make_req(OP_JOIN, 4'd0));
      send_word(make_req(OP_JOIN, 4'd15));
      send_word(make_req(OP_YIELD, 4'd0));
      for (int i = 0; i < 15; i++) begin
         send_word(make_req(OP_CREATE, 4'd15));
      end
      send_word(make_req(OP_CREATE, 4'd0));
      send_word(make_req(OP_JOIN, 4'd5));
      send_word(make_req(OP_FINISH, 4'd0));
      send_word(make_req(OP_JOIN, 4'd1));
      send_word(make_req(OP_JOIN, 4'd1));
      send_word(make_req(OP_CREATE, 4'd0));
      wait_drain();
      send_word(make_req(OP_JOIN, board.cur_slot));
      wait_drain();

      sent = 0;
      mix = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst; i++) begin
            if (sent % 150 == 0) begin
               mix = $urandom_range(0, 2);
            end
            send_word(pick_request(mix));
            sent++;
            if (sent % 400 == 0) begin
               wait_drain();
            end
         end
         idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end

      wait_drain();
      repeat (30) @(posedge clock);
      board.report_leftover();
      $display("Ran %0d requests: %0d create, %0d yield, %0d join, %0d finish.",
               board.op_count[OP_CREATE] + board.op_count[OP_YIELD] +
               board.op_count[OP_JOIN] + board.op_count[OP_FINISH],
               board.op_count[OP_CREATE], board.op_count[OP_YIELD],
               board.op_count[OP_JOIN], board.op_count[OP_FINISH]);
      $display("Checked %0d responses (ok %0d, no free %0d, invalid %0d, joined %0d,",
               board.checked, board.status_count[STAT_OK], board.status_count[STAT_NOFREE],
               board.status_count[STAT_INVALID], board.status_count[STAT_JOINED]);
      $display("blocked %0d), %0d errors.",
               board.status_count[STAT_BLOCKED], board.failures);
      if (board.failures == 0) begin
         $display("tb_round_robin_thread_slot_scheduler passed");
      end else begin
         $display("tb_round_robin_thread_slot_scheduler failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timed out with %0d responses outstanding.", board.pending());
      $display("tb_round_robin_thread_slot_scheduler failed");
      $finish;
   end

endmodule
